>>> rtl/dfg_pkg.sv
package dfg_pkg;

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// configuration port
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_READ_CODE = CFG_IDX_W'(1);

	// frame length limits (length counts header, length and command)
	localparam logic [7:0] MIN_LEN = 8'd3;

	// reply packet characters
	localparam logic [7:0] CH_ACK   = 8'h2b; // '+'
	localparam logic [7:0] CH_START = 8'h24; // '$'
	localparam logic [7:0] CH_HASH  = 8'h23; // '#'
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_A     = 8'h61; // 'a'

	// character position inside one job
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] LEN_SHORT = IDX_W'(2);
	localparam logic [IDX_W-1:0] LEN_LONG  = IDX_W'(5);

	typedef enum logic [1:0] {
		JOB_START,       // '+', '$'
		JOB_START_EMPTY, // '+', '$', '#', sum hi, sum lo
		JOB_DATA,        // hex hi, hex lo
		JOB_DATA_LAST    // hex hi, hex lo, '#', sum hi, sum lo
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;
		logic [7:0] sum;
	} job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'd0, nib};
		end else begin
			c = CH_A + {4'd0, nib - 4'd10};
		end
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] job_len(input job_kind_t kind);
		logic [IDX_W-1:0] n;
		case (kind)
			JOB_START_EMPTY, JOB_DATA_LAST: n = LEN_LONG;
			default:                        n = LEN_SHORT;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] job_char(input job_t job, input logic [IDX_W-1:0] idx);
		logic [7:0] c;
		logic       is_start;
		is_start = (job.kind == JOB_START) || (job.kind == JOB_START_EMPTY);
		case (idx)
			IDX_W'(0): c = is_start ? CH_ACK : hex_char(job.data[7:4]);
			IDX_W'(1): c = is_start ? CH_START : hex_char(job.data[3:0]);
			IDX_W'(2): c = CH_HASH;
			IDX_W'(3): c = hex_char(job.sum[7:4]);
			default:   c = hex_char(job.sum[3:0]);
		endcase
		return c;
	endfunction

endpackage

>>> rtl/dfg_front.sv
module dfg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rx_valid,
	output logic                           rx_ready,
	input  logic [7:0]                     rx_byte,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dfg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           q_full,
	output logic                           push,
	output dfg_pkg::job_t                  push_job
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN,
		PH_CMD,
		PH_DATA
	} phase_t;

	phase_t     phase_q;
	logic [6:0] bytes_left_q;
	logic       is_read_q;
	logic [7:0] sum_q;
	logic [7:0] header_q;
	logic [7:0] read_code_q;

	logic       take;
	logic [6:0] left_next;
	logic [7:0] hex_hi;
	logic [7:0] hex_lo;
	logic [7:0] sum_next;
	logic       cmd_is_read;

	assign rx_ready  = !q_full;
	assign cfg_ready = 1'b1;
	assign take      = rx_valid && rx_ready;

	assign left_next   = bytes_left_q - 7'd1;
	assign hex_hi      = dfg_pkg::hex_char(rx_byte[7:4]);
	assign hex_lo      = dfg_pkg::hex_char(rx_byte[3:0]);
	assign sum_next    = sum_q + hex_hi + hex_lo;
	assign cmd_is_read = (rx_byte == read_code_q);

	// job generation for the current byte
	always_comb begin
		push          = 1'b0;
		push_job.kind = dfg_pkg::JOB_START;
		push_job.data = rx_byte;
		push_job.sum  = sum_next;
		case (phase_q)
			PH_CMD: begin
				push          = take && cmd_is_read;
				push_job.kind = (bytes_left_q == 7'd0) ? dfg_pkg::JOB_START_EMPTY
				                                       : dfg_pkg::JOB_START;
				push_job.sum  = 8'd0;
			end
			PH_DATA: begin
				push          = take && is_read_q;
				push_job.kind = (left_next == 7'd0) ? dfg_pkg::JOB_DATA_LAST
				                                    : dfg_pkg::JOB_DATA;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= 7'd0;
			is_read_q    <= 1'b0;
			sum_q        <= 8'd0;
			header_q     <= 8'd0;
			read_code_q  <= 8'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == dfg_pkg::REG_HEADER) begin
					header_q <= cfg_data;
				end else if (cfg_index == dfg_pkg::REG_READ_CODE) begin
					read_code_q <= cfg_data;
				end
			end
			if (take) begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == header_q) begin
							phase_q <= PH_LEN;
						end
					end
					PH_LEN: begin
						// bad length drops the frame
						if (rx_byte < dfg_pkg::MIN_LEN || rx_byte[7]) begin
							phase_q <= PH_HUNT;
						end else begin
							bytes_left_q <= 7'(rx_byte - dfg_pkg::MIN_LEN);
							phase_q      <= PH_CMD;
						end
					end
					PH_CMD: begin
						is_read_q <= cmd_is_read;
						sum_q     <= 8'd0;
						phase_q   <= (bytes_left_q == 7'd0) ? PH_HUNT : PH_DATA;
					end
					default: begin
						if (is_read_q) begin
							sum_q <= sum_next;
						end
						bytes_left_q <= left_next;
						if (left_next == 7'd0) begin
							phase_q <= PH_HUNT;
						end
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/dfg_queue.sv
module dfg_queue #(
	parameter int DEPTH = dfg_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dfg_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output dfg_pkg::job_t q_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dfg_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != CNT_W'(0));
	assign q_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("job popped from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not follow push");
`endif

endmodule

>>> rtl/dfg_back.sv
module dfg_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  dfg_pkg::job_t q_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_char,
	output logic          last
);

	dfg_pkg::job_t              job_q;
	logic [dfg_pkg::IDX_W-1:0] idx_q;
	logic                       busy_q;
	logic                       out_valid_q;
	logic [7:0]                 out_char_q;
	logic                       out_last_q;

	logic load_en;
	logic emit;
	logic finishing;
	logic cur_last;

	assign load_en   = !out_valid_q || out_ready;
	assign emit      = busy_q && load_en;
	assign finishing = busy_q && (idx_q == dfg_pkg::job_len(job_q.kind) - dfg_pkg::IDX_W'(1));
	assign pop       = q_valid && (!busy_q || (finishing && load_en));
	// only the long jobs close a reply
	assign cur_last  = finishing && (job_q.kind == dfg_pkg::JOB_START_EMPTY ||
	                                 job_q.kind == dfg_pkg::JOB_DATA_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_en) begin
				out_valid_q <= emit;
			end
			if (pop) begin
				idx_q  <= '0;
				busy_q <= 1'b1;
			end else if (emit) begin
				if (finishing) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + dfg_pkg::IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			out_char_q <= dfg_pkg::job_char(job_q, idx_q);
			out_last_q <= cur_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = out_last_q;

`ifndef SYNTHESIS
	a_last_is_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |->
			((out_char_q >= dfg_pkg::CH_ZERO && out_char_q <= 8'h39) ||
			 (out_char_q >= dfg_pkg::CH_A && out_char_q <= 8'h66)))
		else $error("flagged character is not a hex digit");
`endif

endmodule

>>> rtl/debug_frame_to_gdb_reply_core.sv
// path: a byte's job goes via the job queue and the back-end job register to the output register
// throughput: one reply character per cycle from the back end while out_ready is high;
// a read-reply payload byte gives two characters (five for the last, whose job adds the trailer)
// the front takes a byte every cycle while the job queue has room (QUEUE_DEPTH jobs)
// reset: arst_n low clears parser phase, counters, config registers and the queue at once
// no clearing pass after reset: the block is ready as soon as reset is released
module debug_frame_to_gdb_reply_core #(
	parameter int QUEUE_DEPTH = dfg_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// byte stream from the serial link
	input  logic                           rx_valid,
	output logic                           rx_ready,
	input  logic [7:0]                     rx_byte,
	// register writes: index 0 header byte, index 1 read reply code
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dfg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	// reply characters toward the debugger
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_char,
	output logic                           last
);

	// jobs from the frame parser to the character generator
	logic          push;
	dfg_pkg::job_t push_job;
	logic          q_full;
	logic          pop;
	logic          q_valid;
	dfg_pkg::job_t q_job;

	// front end: frame parser, tracks header, length and command, keeps the
	// running checksum and turns each byte into at most one job
	dfg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	// short job queue so parser and generator stall on their own
	dfg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	// back end: walks each job one character per transfer into the output register
	dfg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.last      (last)
	);

endmodule
